FILE: rtl/core/rsp_packet_rle_framer_core_macros.svh
// assertion helpers shared by the framer core modules
`ifndef RSP_PACKET_RLE_FRAMER_CORE_MACROS_SVH
`define RSP_PACKET_RLE_FRAMER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rspf check failed");

// next-cycle implication, checked out of reset
`define RSPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rspf check failed");

`endif

FILE: rtl/core/rspf_pkg.sv
package rspf_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] COUNT_BIAS  = 8'd29;
    localparam logic [7:0] RUN_CAP     = 8'd226;
    localparam logic [7:0] RUN_MIN     = 8'd3;
    localparam logic [7:0] CAP_COUNT   = 8'd255;

    // positions of the output slots of one command, in emission order
    localparam int unsigned NUM_SLOTS = 8;
    localparam logic [2:0] SLOT_DOLLAR = 3'd0;
    localparam logic [2:0] SLOT_CNT_A  = 3'd1;
    localparam logic [2:0] SLOT_HELD   = 3'd2;
    localparam logic [2:0] SLOT_SYM    = 3'd3;
    localparam logic [2:0] SLOT_CNT_B  = 3'd4;
    localparam logic [2:0] SLOT_HASH   = 3'd5;
    localparam logic [2:0] SLOT_HI     = 3'd6;
    localparam logic [2:0] SLOT_LO     = 3'd7;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic [1:0]           held_n;
        logic [7:0]           held_char;
        logic [7:0]           sym;
        logic [7:0]           cnt;
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h37 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/rspf_if.sv
interface rspf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_packet;
    logic       no_payload;

    modport source (output valid, data_byte, last_of_packet, no_payload, input ready);
    modport sink   (input valid, data_byte, last_of_packet, no_payload, output ready);
endinterface

interface rspf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_frame;

    modport source (output valid, out_byte, last_of_frame, input ready);
    modport sink   (input valid, out_byte, last_of_frame, output ready);
endinterface

FILE: rtl/core/rspf_front.sv
module rspf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rspf_in_if.sink             i_in,
    input  logic                i_full,
    output logic                o_push,
    output rspf_pkg::t_cmd      o_cmd
);

    logic [1:0] r_seen, n_seen;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_run,  n_run;
    logic       r_open, n_open;

    logic       acc;
    logic [7:0] run_inc;

    assign i_in.ready = ~i_full;
    assign acc        = i_in.valid && i_in.ready;
    assign run_inc    = r_run + 8'd1;

    always_comb begin
        n_seen = r_seen;
        n_prev = r_prev;
        n_run  = r_run;
        n_open = r_open;
        o_cmd  = '0;
        o_push = 1'b0;
        // an empty beat that does not close the packet is dropped
        if (acc && !(i_in.no_payload && !i_in.last_of_packet)) begin
            if (!r_open) begin
                o_cmd.slots[rspf_pkg::SLOT_DOLLAR] = 1'b1;
            end
            n_open          = 1'b1;
            o_cmd.held_char = r_prev;
            if (!i_in.no_payload) begin
                if (r_seen == 2'd0) begin
                    o_cmd.slots[rspf_pkg::SLOT_SYM] = 1'b1;
                    o_cmd.sym = i_in.data_byte;
                    n_prev    = i_in.data_byte;
                    n_seen    = 2'd1;
                end else if (r_run != 8'd0) begin
                    if (i_in.data_byte == r_prev) begin
                        if (run_inc >= rspf_pkg::RUN_CAP) begin
                            o_cmd.slots[rspf_pkg::SLOT_CNT_A] = 1'b1;
                            o_cmd.cnt = rspf_pkg::CAP_COUNT;
                            n_run     = 8'd0;
                        end else begin
                            n_run = run_inc;
                        end
                    end else begin
                        o_cmd.slots[rspf_pkg::SLOT_CNT_A] = 1'b1;
                        o_cmd.slots[rspf_pkg::SLOT_SYM]   = 1'b1;
                        o_cmd.cnt = r_run + rspf_pkg::COUNT_BIAS;
                        o_cmd.sym = i_in.data_byte;
                        n_run     = 8'd0;
                        n_prev    = i_in.data_byte;
                        n_seen    = 2'd1;
                    end
                end else if (i_in.data_byte == r_prev) begin
                    // third held repeat opens a run
                    if (r_seen == 2'd3) begin
                        o_cmd.slots[rspf_pkg::SLOT_SYM] = 1'b1;
                        o_cmd.sym = rspf_pkg::CHAR_STAR;
                        n_run     = rspf_pkg::RUN_MIN;
                        n_seen    = 2'd1;
                    end else begin
                        n_seen = r_seen + 2'd1;
                    end
                end else begin
                    o_cmd.held_n = r_seen - 2'd1;
                    o_cmd.slots[rspf_pkg::SLOT_SYM] = 1'b1;
                    o_cmd.sym = i_in.data_byte;
                    n_prev    = i_in.data_byte;
                    n_seen    = 2'd1;
                end
            end
            if (i_in.last_of_packet) begin
                if (n_run != 8'd0) begin
                    o_cmd.slots[rspf_pkg::SLOT_CNT_B] = 1'b1;
                    o_cmd.cnt = n_run + rspf_pkg::COUNT_BIAS;
                end
                if (n_seen > 2'd1) begin
                    o_cmd.held_n = n_seen - 2'd1;
                end
                o_cmd.slots[rspf_pkg::SLOT_HASH] = 1'b1;
                o_cmd.slots[rspf_pkg::SLOT_HI]   = 1'b1;
                o_cmd.slots[rspf_pkg::SLOT_LO]   = 1'b1;
                n_seen = 2'd0;
                n_prev = 8'd0;
                n_run  = 8'd0;
                n_open = 1'b0;
            end
            o_cmd.slots[rspf_pkg::SLOT_HELD] = (o_cmd.held_n != 2'd0);
            o_push = |o_cmd.slots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            r_prev <= 8'd0;
            r_run  <= 8'd0;
            r_open <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_prev <= n_prev;
            r_run  <= n_run;
            r_open <= n_open;
        end
    end

`include "rsp_packet_rle_framer_core_macros.svh"

    `RSPF_ASSERT_NOW(a_run_single_seen, r_run != 8'd0, r_seen == 2'd1)
    `RSPF_ASSERT_NOW(a_seen_needs_open, r_seen != 2'd0, r_open)

endmodule

FILE: rtl/core/rspf_queue.sv
module rspf_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rspf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output rspf_pkg::t_cmd o_head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rspf_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`include "rsp_packet_rle_framer_core_macros.svh"

    `RSPF_ASSERT_NOW(a_no_overflow, i_push, !o_full)

endmodule

FILE: rtl/core/rspf_back.sv
module rspf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  rspf_pkg::t_cmd i_head,
    output logic           o_pop,
    rspf_out_if.source     o_out
);

    rspf_pkg::t_cmd r_act, n_act;
    logic [7:0]     r_sum, n_sum;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_byte,  n_out_byte;
    logic           r_out_last,  n_out_last;

    rspf_pkg::t_cmd cur;
    logic           use_head;
    logic           adv;
    logic [2:0]     pick;
    logic [7:0]     byte_sel;
    logic           counted;

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.last_of_frame = r_out_last;

    // an idle slot set takes the queue head straight away
    assign use_head = (r_act.slots == '0) && !i_empty;
    assign cur      = use_head ? i_head : r_act;
    assign adv      = (|cur.slots) && (!r_out_valid || o_out.ready);
    assign o_pop    = adv && use_head;

    always_comb begin
        pick = rspf_pkg::SLOT_LO;
        for (int i = rspf_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (cur.slots[i]) begin
                pick = 3'(i);
            end
        end
    end

    always_comb begin
        counted = 1'b0;
        case (pick)
            rspf_pkg::SLOT_DOLLAR: byte_sel = rspf_pkg::CHAR_DOLLAR;
            rspf_pkg::SLOT_CNT_A: begin
                byte_sel = cur.cnt;
                counted  = 1'b1;
            end
            rspf_pkg::SLOT_HELD: begin
                byte_sel = cur.held_char;
                counted  = 1'b1;
            end
            rspf_pkg::SLOT_SYM: begin
                byte_sel = cur.sym;
                counted  = 1'b1;
            end
            rspf_pkg::SLOT_CNT_B: begin
                byte_sel = cur.cnt;
                counted  = 1'b1;
            end
            rspf_pkg::SLOT_HASH:   byte_sel = rspf_pkg::CHAR_HASH;
            rspf_pkg::SLOT_HI:     byte_sel = rspf_pkg::hex_digit(r_sum[7:4]);
            rspf_pkg::SLOT_LO:     byte_sel = rspf_pkg::hex_digit(r_sum[3:0]);
            default:               byte_sel = 8'd0;
        endcase
    end

    always_comb begin
        n_act       = r_act;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (adv) begin
            n_act = cur;
            if (pick == rspf_pkg::SLOT_HELD && cur.held_n != 2'd1) begin
                n_act.held_n = cur.held_n - 2'd1;
            end else begin
                n_act.slots[pick] = 1'b0;
            end
            if (counted) begin
                n_sum = r_sum + byte_sel;
            end
            if (pick == rspf_pkg::SLOT_LO) begin
                n_sum = 8'd0;
            end
            n_out_valid = 1'b1;
            n_out_byte  = byte_sel;
            n_out_last  = (pick == rspf_pkg::SLOT_LO);
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= '0;
            r_sum       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_act       <= n_act;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

`include "rsp_packet_rle_framer_core_macros.svh"

    `RSPF_ASSERT_NEXT(a_sum_cleared, adv && pick == rspf_pkg::SLOT_LO, r_sum == 8'd0)
    `RSPF_ASSERT_NOW(a_held_count, r_act.slots[rspf_pkg::SLOT_HELD], r_act.held_n != 2'd0)

endmodule

FILE: rtl/core/rsp_packet_rle_framer_core.sv
// Run-length framer for remote-debug packets.
// i_in carries payload beats: data_byte, last_of_packet, and no_payload for a
// beat without a byte (an empty beat only matters when it closes the packet).
// o_out carries the framed stream: '$', compressed payload with '*'+count
// tokens, '#', two upper-case hex checksum digits; last_of_frame marks the
// second digit.
// Each accepted beat is classified combinationally by the front end into a
// command of up to six output bytes, held in a QUEUE_DEPTH-entry queue.
// While o_out is not stalled, the back end drains one byte per cycle into a
// registered output, which a beat's first byte reaches via its queue entry.
// Input rate is one beat per cycle; a beat that yields several bytes holds
// the output until all are sent, so end-of-packet bursts (up to six bytes)
// fill the queue and i_in.ready drops while it is full.
// A stall on o_out holds the output register; the queue keeps taking beats
// until it fills. Reset clears the run state, checksum, queue and output
// valid; the next beat starts a new frame.
module rsp_packet_rle_framer_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rspf_in_if.sink    i_in,
    rspf_out_if.source o_out
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    rspf_pkg::t_cmd cmd;
    rspf_pkg::t_cmd head;

    rspf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    rspf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    rspf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
